### design/ypc_pkg.sv
// Package for the yaw-rotated position controller: widths, CORDIC constants,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
package ypc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int POS_FRAC_BITS = 16;
  localparam int ATAN_ROM_SIZE = 24;
  localparam int NSTG = (CORDIC_STAGES < ATAN_ROM_SIZE) ? CORDIC_STAGES : ATAN_ROM_SIZE;

  localparam int VW = 36;  // vectoring x/y
  localparam int AW = 28;  // angle, 2^-24 rad
  localparam int CW = 33;  // cos/sin, Q1.30
  localparam int PW = 26;  // offset position

  localparam logic signed [AW-1:0] ANG_PI      = AW'(52707179);
  localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(26353589);
  localparam logic signed [CW-1:0] CORDIC_K    = CW'(652032874);

  typedef enum logic [7:0] {
    REG_GAIN = 8'd0, REG_TILT = 8'd1, REG_THRUST = 8'd2, REG_TGT_X = 8'd3,
    REG_TGT_Y = 8'd4, REG_TGT_Z = 8'd5, REG_OFF_X = 8'd6, REG_OFF_Z = 8'd7
  } reg_idx_t;

  localparam logic [15:0] GAIN_RST   = 16'd1280;
  localparam logic [22:0] TILT_RST   = 23'((64'd1 << POS_FRAC_BITS));
  localparam logic [22:0] THRUST_RST = 23'((64'd10 << POS_FRAC_BITS));
  localparam logic [23:0] TGT_Z_RST  = 24'(((64'd2 << POS_FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [23:0] OFF_X_RST  = 24'(((64'd13 << POS_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [23:0] OFF_Z_RST  = 24'(((64'd12 << POS_FRAC_BITS) + 64'd50) / 64'd100);

  // Position carried alongside the CORDIC pipelines.
  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
  } pos_t;

  function automatic logic signed [AW-1:0] atan_val(input int i);
    logic [24:0] v;
    case (i)
      0: v = 25'd13176795;  1: v = 25'd7778716;  2: v = 25'd4110060;
      3: v = 25'd2086331;   4: v = 25'd1047214;  5: v = 25'd524117;
      6: v = 25'd262123;    7: v = 25'd131069;   8: v = 25'd65536;
      9: v = 25'd32768;    10: v = 25'd16384;   11: v = 25'd8192;
      12: v = 25'd4096;    13: v = 25'd2048;    14: v = 25'd1024;
      15: v = 25'd512;     16: v = 25'd256;     17: v = 25'd128;
      18: v = 25'd64;      19: v = 25'd32;      20: v = 25'd16;
      21: v = 25'd8;       22: v = 25'd4;       23: v = 25'd2;
      default: v = 25'd0;
    endcase
    return AW'(signed'({1'b0, v}));
  endfunction

endpackage

### design/ypc_if.sv
// Channel interfaces: pose input, command output, register write port.
// Depends on nothing.
`timescale 1ns / 1ps
interface ypc_pose_if;
  logic valid, ready;
  logic [23:0] trans_x, trans_y, trans_z;
  logic [15:0] quat_x, quat_y, quat_z, quat_w;
  modport source (output valid, trans_x, trans_y, trans_z, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, trans_x, trans_y, trans_z, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface

interface ypc_cmd_if;
  logic valid, ready;
  logic [23:0] cmd_roll, cmd_pitch, cmd_thrust;
  logic [2:0] sat_flags;
  modport source (output valid, cmd_roll, cmd_pitch, cmd_thrust, sat_flags, input ready);
  modport sink (input valid, cmd_roll, cmd_pitch, cmd_thrust, sat_flags, output ready);
endinterface

interface ypc_cfg_if;
  logic valid, ready;
  logic [7:0] index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/yaw_rotated_p_position_ctrl.sv
// Top level of the yaw-rotated proportional position controller.
// Depends on ypc_pkg, ypc_if, ypc_atan and ypc_sincos.
`timescale 1ns / 1ps
// One pose sample in, one clamped command triple out. The block is a single
// pipeline that takes a new sample every cycle unless the output stalls; its
// two unrolled CORDICs run 16 iterations with one register per iteration.
// The whole pipeline advances together whenever the output register is empty
// or its transfer completes, so a stall on the command side holds every stage
// and nothing is lost or repeated. Registers are written through the cfg port
// (always ready); write them only while no sample is in flight.
module yaw_rotated_p_position_ctrl import ypc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ypc_pose_if.sink pose,
  ypc_cmd_if.source cmd,
  ypc_cfg_if.sink  cfg
);
  logic        en;
  logic [15:0] gain;
  logic [22:0] tilt_limit, thrust_limit;
  logic signed [23:0] target_x, target_y, target_z, offset_x, offset_z;

  // Advance when the output register can take a new result.
  assign en = !cmd.valid || cmd.ready;
  assign pose.ready = en;
  assign cfg.ready = 1'b1;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RST;
      tilt_limit <= TILT_RST;
      thrust_limit <= THRUST_RST;
      target_x <= '0;
      target_y <= '0;
      target_z <= TGT_Z_RST;
      offset_x <= OFF_X_RST;
      offset_z <= OFF_Z_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAIN:   gain <= cfg.data[15:0];
        REG_TILT:   tilt_limit <= cfg.data[22:0];
        REG_THRUST: thrust_limit <= cfg.data[22:0];
        REG_TGT_X:  target_x <= cfg.data;
        REG_TGT_Y:  target_y <= cfg.data;
        REG_TGT_Z:  target_z <= cfg.data;
        REG_OFF_X:  offset_x <= cfg.data;
        REG_OFF_Z:  offset_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage 1: offset position and quaternion products.
  logic               v1;
  pos_t               pos1;
  logic signed [31:0] qyy, qzz, qwz, qxy;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pose.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos1.px <= -PW'($signed(pose.trans_x)) - PW'(offset_x);
      pos1.py <= -PW'($signed(pose.trans_y));
      pos1.pz <= PW'($signed(pose.trans_z)) - PW'(offset_z);
      qyy <= $signed(pose.quat_y) * $signed(pose.quat_y);
      qzz <= $signed(pose.quat_z) * $signed(pose.quat_z);
      qwz <= $signed(pose.quat_w) * $signed(pose.quat_z);
      qxy <= $signed(pose.quat_x) * $signed(pose.quat_y);
    end
  end

  // Stage 2: atan2 operands and the pre-rotation by pi for the left half-plane.
  logic signed [VW-1:0] den, num;
  logic                 v2;
  pos_t                 pos2;
  logic signed [VW-1:0] vx2, vy2;
  logic signed [AW-1:0] ang2;
  assign den = (VW'(1) <<< 30) - ((VW'(qyy) + VW'(qzz)) <<< 1);
  assign num = (VW'(qwz) + VW'(qxy)) <<< 1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos2 <= pos1;
      if (den < 0) begin
        ang2 <= (num >= 0) ? ANG_PI : -ANG_PI;
        vx2 <= -den;
        vy2 <= -num;
      end else begin
        ang2 <= '0;
        vx2 <= den;
        vy2 <= num;
      end
    end
  end

  logic                 va;
  logic signed [AW-1:0] anga;
  pos_t                 posa;
  ypc_atan u_atan (
    .clk, .rst, .en, .in_valid(v2), .vx_in(vx2), .vy_in(vy2), .ang_in(ang2),
    .pos_in(pos2), .out_valid(va), .ang_out(anga), .pos_out(posa)
  );

  logic                 vs;
  logic signed [CW-1:0] cs, sn;
  pos_t                 poss;
  ypc_sincos u_sincos (
    .clk, .rst, .en, .in_valid(va), .ang_in(anga), .pos_in(posa),
    .out_valid(vs), .cos_out(cs), .sin_out(sn), .pos_out(poss)
  );

  // Rotation products.
  localparam int MW = PW + CW;
  logic                 vm;
  logic signed [MW-1:0] pxc, pys, pxs, pyc;
  logic signed [PW-1:0] pzm;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vs;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pxc <= MW'(poss.px) * MW'(cs);
      pys <= MW'(poss.py) * MW'(sn);
      pxs <= MW'(poss.px) * MW'(sn);
      pyc <= MW'(poss.py) * MW'(cs);
      pzm <= poss.pz;
    end
  end

  // Sum, round to position LSBs and negate.
  localparam int RW = 28;
  logic signed [MW:0]   xs, ys;
  logic                 vr;
  logic signed [RW-1:0] xr, yr;
  logic signed [PW-1:0] pzr;
  assign xs = (MW+1)'(pxc) - (MW+1)'(pys) + ((MW+1)'(1) <<< 29);
  assign ys = (MW+1)'(pxs) + (MW+1)'(pyc) + ((MW+1)'(1) <<< 29);
  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= vm;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      xr <= -RW'(xs >>> 30);
      yr <= -RW'(ys >>> 30);
      pzr <= pzm;
    end
  end

  // Errors against the setpoints.
  localparam int EW = RW + 1;
  logic                 ve;
  logic signed [EW-1:0] ex, ey, ez;
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vr;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ex <= EW'(target_x) - EW'(xr);
      ey <= EW'(target_y) - EW'(yr);
      ez <= EW'(target_z) - EW'(pzr);
    end
  end

  // Gain products.
  localparam int GW = EW + 17;
  logic                 vg;
  logic signed [GW-1:0] gx, gy, gz;
  logic signed [GW-1:0] gs;
  assign gs = GW'($signed({1'b0, gain}));
  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= ve;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      gx <= GW'(ex) * gs;
      gy <= GW'(ey) * gs;
      gz <= GW'(ez) * gs;
    end
  end

  // Round from 2^-8, clamp and hold in the output register.
  logic signed [GW-1:0] rx, ry, rz, lt, lh;
  assign rx = (gx + GW'(128)) >>> 8;
  assign ry = (gy + GW'(128)) >>> 8;
  assign rz = (gz + GW'(128)) >>> 8;
  assign lt = GW'($signed({1'b0, tilt_limit}));
  assign lh = GW'($signed({1'b0, thrust_limit}));

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (en) begin
      cmd.valid <= vg;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd.sat_flags <= {(rz > lh) || (rz < -lh), (rx > lt) || (rx < -lt),
                        (ry > lt) || (ry < -lt)};
      cmd.cmd_roll  <= (ry > lt) ? lt[23:0] : (ry < -lt) ? -lt[23:0] : ry[23:0];
      cmd.cmd_pitch <= (rx > lt) ? lt[23:0] : (rx < -lt) ? -lt[23:0] : rx[23:0];
      cmd.cmd_thrust <= (rz > lh) ? lh[23:0] : (rz < -lh) ? -lh[23:0] : rz[23:0];
    end
  end
endmodule

### design/ypc_atan.sv
// Vectoring CORDIC pipeline: one register stage per iteration, angle out.
// Depends on ypc_pkg.
`timescale 1ns / 1ps
module ypc_atan import ypc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] vx_in,
  input  logic signed [VW-1:0] vy_in,
  input  logic signed [AW-1:0] ang_in,
  input  pos_t                 pos_in,
  output logic                 out_valid,
  output logic signed [AW-1:0] ang_out,
  output pos_t                 pos_out
);
  logic signed [VW-1:0] vx [NSTG+1];
  logic signed [VW-1:0] vy [NSTG+1];
  logic signed [AW-1:0] ang [NSTG+1];
  pos_t                 pos [NSTG+1];
  logic [NSTG:0]        vld;

  assign vx[0] = vx_in;
  assign vy[0] = vy_in;
  assign ang[0] = ang_in;
  assign pos[0] = pos_in;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pos[i+1] <= pos[i];
        if (vy[i] >= 0) begin
          vx[i+1]  <= vx[i] + (vy[i] >>> i);
          vy[i+1]  <= vy[i] - (vx[i] >>> i);
          ang[i+1] <= ang[i] + atan_val(i);
        end else begin
          vx[i+1]  <= vx[i] - (vy[i] >>> i);
          vy[i+1]  <= vy[i] + (vx[i] >>> i);
          ang[i+1] <= ang[i] - atan_val(i);
        end
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign ang_out   = ang[NSTG];
  assign pos_out   = pos[NSTG];
endmodule

### design/ypc_sincos.sv
// Rotation CORDIC pipeline: negates the angle, folds it into +-pi/2, then
// one register stage per iteration and a final sign-flip stage. Depends on ypc_pkg.
`timescale 1ns / 1ps
module ypc_sincos import ypc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] ang_in,
  input  pos_t                 pos_in,
  output logic                 out_valid,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out,
  output pos_t                 pos_out
);
  logic signed [CW-1:0] c [NSTG+1];
  logic signed [CW-1:0] s [NSTG+1];
  logic signed [AW-1:0] ang [NSTG+1];
  logic [NSTG:0]        flip;
  pos_t                 pos [NSTG+1];
  logic [NSTG:0]        vld;
  logic signed [AW-1:0] yaw;

  assign yaw = -ang_in;

  // fold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos[0] <= pos_in;
      c[0]   <= CORDIC_K;
      s[0]   <= '0;
      if (yaw > ANG_HALF_PI) begin
        ang[0] <= yaw - ANG_PI;
        flip[0] <= 1'b1;
      end else if (yaw < -ANG_HALF_PI) begin
        ang[0] <= yaw + ANG_PI;
        flip[0] <= 1'b1;
      end else begin
        ang[0] <= yaw;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pos[i+1]  <= pos[i];
        flip[i+1] <= flip[i];
        if (ang[i] >= 0) begin
          c[i+1]   <= c[i] - (s[i] >>> i);
          s[i+1]   <= s[i] + (c[i] >>> i);
          ang[i+1] <= ang[i] - atan_val(i);
        end else begin
          c[i+1]   <= c[i] + (s[i] >>> i);
          s[i+1]   <= s[i] - (c[i] >>> i);
          ang[i+1] <= ang[i] + atan_val(i);
        end
      end
    end
  end

  // sign-flip stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NSTG];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pos_out <= pos[NSTG];
      cos_out <= flip[NSTG] ? -c[NSTG] : c[NSTG];
      sin_out <= flip[NSTG] ? -s[NSTG] : s[NSTG];
    end
  end
endmodule

### design/ypc_checker.sv
// Port-level checks for the position controller, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module ypc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_roll,
  input logic        cfg_ready
);
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output state");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_roll))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("register port not ready");
endmodule

bind yaw_rotated_p_position_ctrl ypc_checker u_ypc_checker (
  .clk(clk), .rst(rst), .in_ready(pose.ready),
  .out_valid(cmd.valid), .out_ready(cmd.ready), .out_roll(cmd.cmd_roll),
  .cfg_ready(cfg.ready)
);

### bench/yaw_rotated_p_position_ctrl_tb.sv
// Self-checking bench for yaw_rotated_p_position_ctrl: directed pose table, then
// random poses over several register settings, checked against a local predictor.
// Depends on ypc_pkg, ypc_if and the RTL of the block.
`timescale 1ns / 1ps
module yaw_rotated_p_position_ctrl_tb;
  import ypc_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int PIPE_DEPTH  = 41;
  localparam int DRAIN_SLACK = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;
  // Index past the register file; the block must ignore writes to it.
  localparam logic [7:0] REG_UNUSED = 8'd200;

  typedef struct {
    logic [23:0] tx, ty, tz;
    logic [15:0] qx, qy, qz, qw;
  } pose_t;

  typedef struct {
    logic [23:0] roll, pitch, thrust;
    logic [2:0]  flags;
  } cmd_t;

  typedef struct {
    pose_t p;
    bit    known;
    cmd_t  c;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ypc_pose_if pose_ch();
  ypc_cmd_if  cmd_ch();
  ypc_cfg_if  cfg_ch();

  yaw_rotated_p_position_ctrl i_dut (
    .clk  (clk),
    .rst  (rst),
    .pose (pose_ch.sink),
    .cmd  (cmd_ch.source),
    .cfg  (cfg_ch.sink)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow copy of the register file, updated on each write transfer.
  logic [15:0] kp;
  logic [22:0] tilt_lim, thrust_lim;
  logic [23:0] tgt_x, tgt_y, tgt_z, off_x, off_z;

  longint arctan_lut[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  cmd_t   pending_cmds[$];
  int     errors = 0;
  int     poses_sent = 0;
  int     cmds_seen = 0;
  int     clamps_seen = 0;
  bit     no_gaps = 0;
  bit     hold_request = 0;

  function automatic longint sx(input logic [23:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sq(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // Half-up rounding: add half an LSB then floor shift.
  function automatic longint round_down(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint limit_cmd(input longint v, input longint lim,
                                       inout logic [2:0] fl, input int b);
    if (v > lim) begin
      fl[b] = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      fl[b] = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // Expected command triple for one pose under the current register values.
  function automatic cmd_t predict_cmd(input pose_t p);
    longint qx, qy, qz, qw, vx, vy, yaw, c, s, dx, dy;
    longint px, py, pz, xr, yr, r, pt, th;
    logic [2:0] fl;
    bit flip;
    cmd_t o;
    qx = sq(p.qx); qy = sq(p.qy); qz = sq(p.qz); qw = sq(p.qw);
    vx = (longint'(1) << 30) - 2 * (qy * qy + qz * qz);
    vy = 2 * (qw * qz + qx * qy);
    yaw = 0;
    fl = '0;
    flip = 0;
    // Pre-rotate by pi into the right half plane.
    if (vx < 0) begin
      yaw = (vy >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < NSTG; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; yaw += arctan_lut[i];
      end else begin
        vx -= dx; vy += dy; yaw -= arctan_lut[i];
      end
    end
    yaw = -yaw;
    if (yaw > longint'(ANG_HALF_PI)) begin
      yaw -= longint'(ANG_PI); flip = 1;
    end else if (yaw < -longint'(ANG_HALF_PI)) begin
      yaw += longint'(ANG_PI); flip = 1;
    end
    c = longint'(CORDIC_K);
    s = 0;
    for (int i = 0; i < NSTG; i++) begin
      dx = s >>> i;
      dy = c >>> i;
      if (yaw >= 0) begin
        c -= dx; s += dy; yaw -= arctan_lut[i];
      end else begin
        c += dx; s -= dy; yaw += arctan_lut[i];
      end
    end
    if (flip) begin
      c = -c; s = -s;
    end
    px = -sx(p.tx) - sx(off_x);
    py = -sx(p.ty);
    pz = sx(p.tz) - sx(off_z);
    xr = -round_down(px * c - py * s, 30);
    yr = -round_down(px * s + py * c, 30);
    pt = round_down((sx(tgt_x) - xr) * longint'(kp), 8);
    r  = round_down((sx(tgt_y) - yr) * longint'(kp), 8);
    th = round_down((sx(tgt_z) - pz) * longint'(kp), 8);
    r  = limit_cmd(r, longint'(tilt_lim), fl, 0);
    pt = limit_cmd(pt, longint'(tilt_lim), fl, 1);
    th = limit_cmd(th, longint'(thrust_lim), fl, 2);
    o.roll = 24'(r);
    o.pitch = 24'(pt);
    o.thrust = 24'(th);
    o.flags = fl;
    return o;
  endfunction

  function automatic pose_t mk_pose(input int tx, ty, tz, qx, qy, qz, qw);
    pose_t p;
    p.tx = 24'(tx); p.ty = 24'(ty); p.tz = 24'(tz);
    p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz); p.qw = 16'(qw);
    return p;
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    // Mostly poses near the setpoints so the clamps stay open; some full range.
    if ($urandom_range(0, 3) == 0) begin
      p.tx = 24'($urandom); p.ty = 24'($urandom); p.tz = 24'($urandom);
    end else begin
      p.tx = 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      p.ty = 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      p.tz = 24'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    end
    p.qx = 16'($urandom); p.qy = 16'($urandom);
    p.qz = 16'($urandom); p.qw = 16'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      // Small tilt: x and y near zero, yaw spread over the full circle.
      p.qx = 16'($signed(p.qx) >>> 6);
      p.qy = 16'($signed(p.qy) >>> 6);
    end
    return p;
  endfunction

  // Monitor the command channel at the clock edge: compare each command
  // transfer with the oldest queued prediction.
  always @(posedge clk) begin
    cmd_t want;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      cmds_seen++;
      if (cmd_ch.sat_flags != 3'd0) clamps_seen++;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, actual roll %h pitch %h thrust %h flags %b",
                 $time, cmd_ch.cmd_roll, cmd_ch.cmd_pitch, cmd_ch.cmd_thrust,
                 cmd_ch.sat_flags);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_ch.cmd_roll !== want.roll) begin
          $display("%0t: cmd_roll expected %h actual %h", $time, want.roll, cmd_ch.cmd_roll);
          errors++;
        end
        if (cmd_ch.cmd_pitch !== want.pitch) begin
          $display("%0t: cmd_pitch expected %h actual %h", $time, want.pitch,
                   cmd_ch.cmd_pitch);
          errors++;
        end
        if (cmd_ch.cmd_thrust !== want.thrust) begin
          $display("%0t: cmd_thrust expected %h actual %h", $time, want.thrust,
                   cmd_ch.cmd_thrust);
          errors++;
        end
        if (cmd_ch.sat_flags !== want.flags) begin
          $display("%0t: sat_flags expected %b actual %b", $time, want.flags,
                   cmd_ch.sat_flags);
          errors++;
        end
      end
    end
  end

  // Command receiver: random stall per result, and one long hold-off on request.
  initial begin
    int stall;
    cmd_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        cmd_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        cmd_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cmd_ch.ready <= 1'b1;
      do @(posedge clk); while (!cmd_ch.valid);
    end
  end

  // Offer one pose; keep valid high across back-to-back transfers. Queue the
  // prediction at the accepting edge.
  task automatic send_pose(input pose_t p, input bit known, input cmd_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pose_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.trans_x <= p.tx; pose_ch.trans_y <= p.ty; pose_ch.trans_z <= p.tz;
    pose_ch.quat_x <= p.qx; pose_ch.quat_y <= p.qy;
    pose_ch.quat_z <= p.qz; pose_ch.quat_w <= p.qw;
    do @(posedge clk); while (!pose_ch.ready);
    pending_cmds.push_back(known ? c : predict_cmd(p));
    poses_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_GAIN:   kp = val[15:0];
      REG_TILT:   tilt_lim = val[22:0];
      REG_THRUST: thrust_lim = val[22:0];
      REG_TGT_X:  tgt_x = val;
      REG_TGT_Y:  tgt_y = val;
      REG_TGT_Z:  tgt_z = val;
      REG_OFF_X:  off_x = val;
      REG_OFF_Z:  off_z = val;
      default: ;
    endcase
  endtask

  // Wait for every queued command, then let the pipeline empty fully.
  task automatic drain();
    pose_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
    repeat (PIPE_DEPTH + DRAIN_SLACK) @(posedge clk);
  endtask

  // Pick a register value: low end, high end, or a moderate random one.
  function automatic logic [23:0] pick_val(input int lo, hi, mid_lo, mid_hi);
    case ($urandom_range(0, 3))
      0: return 24'(lo);
      1: return 24'(hi);
      default: return 24'(int'($urandom_range(mid_lo, mid_hi)));
    endcase
  endfunction

  initial begin
    table_row_t dir_rows[$];
    cmd_t none, sat_pos, sat_neg;
    int mode;
    none = '{default: '0};
    // Far poses saturate all three commands; yaw stays near zero.
    sat_pos = '{24'h010000, 24'h010000, 24'h0A0000, 3'b111};
    sat_neg = '{24'hFF0000, 24'hFF0000, 24'hF60000, 3'b111};
    dir_rows = '{
      '{mk_pose(0, 0, 0, 0, 0, 0, 0), 0, none},
      '{mk_pose(-8388608, -8388608, -8388608, 0, 0, 0, 0), 1, sat_pos},
      '{mk_pose(8388607, 8388607, 8388607, 0, 0, 0, 0), 1, sat_neg},
      '{mk_pose(0, 0, 0, 0, 0, 0, 32767), 0, none},
      '{mk_pose(0, 0, 13107, 0, 0, 0, -32768), 0, none},
      '{mk_pose(0, 0, 0, 0, 0, 32767, 0), 0, none},
      '{mk_pose(0, 0, 0, 0, 0, -32768, 0), 0, none},
      '{mk_pose(1000, -2000, 0, 0, 0, -32768, 32767), 0, none},
      '{mk_pose(-1000, 2000, 0, 0, 0, 32767, -32768), 0, none},
      '{mk_pose(30000, 0, 0, 0, 23170, 0, 23170), 0, none},
      '{mk_pose(0, 30000, 0, 32767, 32767, 32767, 32767), 0, none},
      '{mk_pose(0, 0, 0, -32768, -32768, -32768, -32768), 0, none},
      '{mk_pose(-30000, -30000, 0, 23170, 0, 23170, 0), 0, none},
      '{mk_pose(65536, 0, 0, 0, 0, 23170, 23170), 0, none},
      '{mk_pose(0, 65536, 0, 0, 0, -23170, 23170), 0, none},
      '{mk_pose(-8520, 0, 7864, 100, -100, 5000, 32000), 0, none}
    };

    pose_ch.valid <= 1'b0;
    pose_ch.trans_x <= '0; pose_ch.trans_y <= '0; pose_ch.trans_z <= '0;
    pose_ch.quat_x <= '0; pose_ch.quat_y <= '0;
    pose_ch.quat_z <= '0; pose_ch.quat_w <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_GAIN;
    cfg_ch.data <= '0;
    kp = GAIN_RST; tilt_lim = TILT_RST; thrust_lim = THRUST_RST;
    tgt_x = '0; tgt_y = '0; tgt_z = TGT_Z_RST; off_x = OFF_X_RST; off_z = OFF_Z_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at reset values, no idling on either side.
    no_gaps = 1;
    foreach (dir_rows[i]) send_pose(dir_rows[i].p, dir_rows[i].known, dir_rows[i].c);
    no_gaps = 0;
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // New settings; phases 1 and 2 pin every register to an extreme.
      if (ph > 0) begin
        mode = (ph == 1) ? 0 : (ph == 2) ? 1 : 2;
        write_reg(REG_GAIN, mode == 0 ? 24'd0 : mode == 1 ? 24'd65535 :
                  pick_val(0, 65535, 64, 2048));
        write_reg(REG_TILT, mode == 0 ? 24'd0 : mode == 1 ? 24'h7FFFFF :
                  pick_val(0, 8388607, 1 << 14, 1 << 19));
        write_reg(REG_THRUST, mode == 0 ? 24'd0 : mode == 1 ? 24'h7FFFFF :
                  pick_val(0, 8388607, 1 << 14, 1 << 21));
        write_reg(REG_TGT_X, mode == 0 ? 24'h800000 : mode == 1 ? 24'h7FFFFF :
                  pick_val(-8388608, 8388607, -(1 << 17), 1 << 17));
        write_reg(REG_TGT_Y, mode == 0 ? 24'h800000 : mode == 1 ? 24'h7FFFFF :
                  pick_val(-8388608, 8388607, -(1 << 17), 1 << 17));
        write_reg(REG_TGT_Z, mode == 0 ? 24'h800000 : mode == 1 ? 24'h7FFFFF :
                  pick_val(-8388608, 8388607, -(1 << 17), 1 << 17));
        write_reg(REG_OFF_X, mode == 0 ? 24'h800000 : mode == 1 ? 24'h7FFFFF :
                  pick_val(-8388608, 8388607, -(1 << 15), 1 << 15));
        write_reg(REG_OFF_Z, mode == 0 ? 24'h800000 : mode == 1 ? 24'h7FFFFF :
                  pick_val(-8388608, 8388607, -(1 << 15), 1 << 15));
        // Drop a write to an unused index; the settings above must survive it.
        write_reg(REG_UNUSED, 24'($urandom));
      end
      // Run phase 3 gap-free, and hold off the receiver once in phase 4.
      no_gaps = (ph == 3);
      if (ph == 4) hold_request = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_pose(random_pose(), 0, none);
      no_gaps = 0;
      drain();
    end

    $display("Sent %0d poses over %0d register settings; %0d commands checked, %0d clamped.",
             poses_sent, PHASES, cmds_seen, clamps_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d commands outstanding", pending_cmds.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
design/ypc_pkg.sv
design/ypc_if.sv
design/ypc_atan.sv
design/ypc_sincos.sv
design/yaw_rotated_p_position_ctrl.sv
design/ypc_checker.sv
bench/yaw_rotated_p_position_ctrl_tb.sv
